// ===== rtl/jsle_pkg.sv =====
package jsle_pkg;

    localparam int LA_DEPTH = 6;
    localparam int TAG_LEN  = 7;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] la_count_t;

    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_DQUOTE = 8'h22;
    localparam byte_t CH_SQUOTE = 8'h27;
    localparam byte_t CH_CR     = 8'h0D;
    localparam byte_t CH_LF     = 8'h0A;
    localparam byte_t CH_SLASH  = 8'h2F;
    localparam byte_t CH_LOW_R  = 8'h72;
    localparam byte_t CH_LOW_N  = 8'h6E;
    localparam byte_t CH_UP_A   = 8'h41;
    localparam byte_t CH_UP_Z   = 8'h5A;
    localparam byte_t CASE_BIT  = 8'h20;

    localparam byte_t SCRIPT_TAG [TAG_LEN] = '{8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};

    // output byte source
    localparam logic [1:0] SEL_QUOTE = 2'd0;
    localparam logic [1:0] SEL_HEAD  = 2'd1;
    localparam logic [1:0] SEL_LOOK  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       ld_char;
        logic       ld_eos;
        logic [1:0] sel;
        logic       emit;
        logic       pfx;
        logic       consume;
        logic       last;
        logic       done;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_gt1;
        logic count_full;
        logic started;
        logic quote_wrap;
        logic need_pfx;
        logic out_free;
    } status_t;

    function automatic byte_t to_lower(input byte_t c);
        byte_t r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

    function automatic logic need_prefix(input byte_t c, input logic aq, input logic script);
        logic r;
        r = (c == CH_BSLASH) || (c == CH_DQUOTE) || (c == CH_CR) || (c == CH_LF)
            || ((c == CH_SQUOTE) && !aq) || ((c == CH_SLASH) && script);
        return r;
    endfunction

    function automatic byte_t esc_char(input byte_t c);
        byte_t r;
        r = c;
        if (c == CH_CR)
        begin
            r = CH_LOW_R;
        end
        else if (c == CH_LF)
        begin
            r = CH_LOW_N;
        end
        return r;
    endfunction

endpackage

// ===== rtl/jsle_in_if.sv =====
interface jsle_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_char;
    logic        no_char;
    logic        end_of_string;

    modport source (output valid, output in_char, output no_char, output end_of_string,
                    input ready);
    modport sink (input valid, input in_char, input no_char, input end_of_string,
                  output ready);
endinterface

// ===== rtl/jsle_out_if.sv =====
interface jsle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        string_done;
    logic        run_last;

    modport source (output valid, output out_char, output string_done, output run_last,
                    input ready);
    modport sink (input valid, input out_char, input string_done, input run_last,
                  output ready);
endinterface

// ===== rtl/js_string_literal_escaper_unit.sv =====
// Channel      Dir   Payload                                   Handshake
// raw_ch       in    in_char[7:0], no_char, end_of_string      valid/ready
// esc_ch       out   out_char[7:0], string_done, run_last      valid/ready
// quote_wrap   cfg   quote_wrap_wdata                          quote_wrap_we
//
// Flow: an item is taken, then its results leave one byte per cycle while
//   esc_ch.ready does not stall, 0 to 15 of them. The single output register,
//   written at most once per cycle, sets that rate.
// Reset: rst_n clears the sequencer, the lookahead count, the string flag,
//   quote_wrap and the output valid. Lookahead bytes hold no reset value.
// Stalls: esc_ch.ready low while a result waits in the output register freezes
//   the sequencer; the last result of an item may sit in the output register
//   while the next transaction is accepted.
module js_string_literal_escaper_unit (
    input  logic        clk,
    input  logic        rst_n,
    jsle_in_if.sink     raw_ch,
    jsle_out_if.source  esc_ch,
    input  logic        quote_wrap_we,
    input  logic        quote_wrap_wdata
);

    jsle_pkg::cmd_t    cmd;
    jsle_pkg::status_t sts;

    // controller: item sequencing (open quote, head byte, flush, close quote)
    jsle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (raw_ch.valid),
        .in_no_char (raw_ch.no_char),
        .in_eos     (raw_ch.end_of_string),
        .in_ready   (raw_ch.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath: lookahead buffer, /script match, escape mapping, output register
    jsle_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (raw_ch.in_char),
        .cfg_we    (quote_wrap_we),
        .cfg_wdata (quote_wrap_wdata),
        .out_ready (esc_ch.ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (esc_ch.valid),
        .out_char  (esc_ch.out_char),
        .out_done  (esc_ch.string_done),
        .out_last  (esc_ch.run_last)
    );

    // a new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!esc_ch.valid || esc_ch.ready))
        else $error("result register overwritten");

    // end of string only ever marks the last result of its transaction
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.done |-> cmd.last)
        else $error("string_done without run_last");

    // no transaction is taken while results of the previous one are pending
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (raw_ch.valid && raw_ch.ready) |-> !cmd.emit)
        else $error("accept during emission");

    // a backslash prefix is always followed by the escaped byte itself
    a_pfx_then_char: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.pfx |=> !raw_ch.ready)
        else $error("item ended after a prefix");

endmodule

// ===== rtl/jsle_ctrl.sv =====
module jsle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_no_char,
    input  logic              in_eos,
    output logic              in_ready,
    input  jsle_pkg::status_t sts,
    output jsle_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_OPEN  = 3'd1;
    localparam logic [2:0] ST_HEAD  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_CLOSE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       phase_reg, phase_next;
    logic       has_head_reg, has_head_next;
    logic       eos_reg, eos_next;

    logic       accept;
    logic       ignore_item;
    logic       entry_head;
    logic [2:0] entry_st;
    logic [2:0] after_head;
    logic [2:0] after_open;
    logic [2:0] after_flush;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign ignore_item = in_no_char && !in_eos;
    assign entry_head  = !in_no_char && sts.count_full;

    // step following the head byte / opening quote (post-load buffer state)
    assign after_head  = !eos_reg ? ST_IDLE :
                         !sts.count_zero ? ST_FLUSH :
                         sts.quote_wrap ? ST_CLOSE : ST_IDLE;
    assign after_open  = has_head_reg ? ST_HEAD : after_head;
    assign after_flush = sts.count_gt1 ? ST_FLUSH :
                         sts.quote_wrap ? ST_CLOSE : ST_IDLE;

    // first step of a fresh item, from pre-load buffer state
    always_comb
    begin
        if (!sts.started && sts.quote_wrap)
        begin
            entry_st = ST_OPEN;
        end
        else if (entry_head)
        begin
            entry_st = ST_HEAD;
        end
        else if (in_eos && (!in_no_char || !sts.count_zero))
        begin
            entry_st = ST_FLUSH;
        end
        else if (in_eos && sts.quote_wrap)
        begin
            entry_st = ST_CLOSE;
        end
        else
        begin
            entry_st = ST_IDLE;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        has_head_next = has_head_reg;
        eos_next      = eos_reg;
        cmd           = '0;
        cmd.sel       = jsle_pkg::SEL_QUOTE;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !ignore_item)
                begin
                    cmd.load      = 1'b1;
                    cmd.ld_char   = !in_no_char;
                    cmd.ld_eos    = in_eos;
                    has_head_next = entry_head;
                    eos_next      = in_eos;
                    phase_next    = 1'b0;
                    state_next    = entry_st;
                end
            end
            ST_OPEN:
            begin
                cmd.sel = jsle_pkg::SEL_QUOTE;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = (after_open == ST_IDLE);
                    state_next = after_open;
                end
            end
            ST_HEAD:
            begin
                cmd.sel = jsle_pkg::SEL_HEAD;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!phase_reg && sts.need_pfx)
                    begin
                        cmd.pfx    = 1'b1;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        cmd.last   = (after_head == ST_IDLE);
                        phase_next = 1'b0;
                        state_next = after_head;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.sel = jsle_pkg::SEL_LOOK;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!phase_reg && sts.need_pfx)
                    begin
                        cmd.pfx    = 1'b1;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        cmd.consume = 1'b1;
                        cmd.last    = (after_flush == ST_IDLE);
                        phase_next  = 1'b0;
                        state_next  = after_flush;
                    end
                end
            end
            ST_CLOSE:
            begin
                cmd.sel = jsle_pkg::SEL_QUOTE;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.done = cmd.last && eos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= 1'b0;
            has_head_reg <= 1'b0;
            eos_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            has_head_reg <= has_head_next;
            eos_reg      <= eos_next;
        end
    end

endmodule

// ===== rtl/jsle_datapath.sv =====
module jsle_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_char,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              out_ready,
    input  jsle_pkg::cmd_t    cmd,
    output jsle_pkg::status_t sts,
    output logic              out_valid,
    output logic [7:0]        out_char,
    output logic              out_done,
    output logic              out_last
);

    jsle_pkg::byte_t    look_reg [jsle_pkg::LA_DEPTH];
    jsle_pkg::la_count_t count_reg;
    jsle_pkg::byte_t    head_reg;
    logic               head_script_reg;
    logic               started_reg;
    logic               aq_reg;

    logic               out_valid_reg;
    jsle_pkg::byte_t    out_char_reg;
    logic               out_done_reg;
    logic               out_last_reg;

    logic               full;
    logic               script_hit;
    jsle_pkg::byte_t    sel_byte;
    logic               sel_script;
    jsle_pkg::byte_t    emit_byte;

    assign full = (count_reg == jsle_pkg::la_count_t'(jsle_pkg::LA_DEPTH));

    // window: six waiting bytes plus the incoming one
    always_comb
    begin
        script_hit = 1'b1;
        for (int i = 0; i < jsle_pkg::LA_DEPTH; i++)
        begin
            if (jsle_pkg::to_lower(look_reg[i]) != jsle_pkg::SCRIPT_TAG[i])
            begin
                script_hit = 1'b0;
            end
        end
        if (jsle_pkg::to_lower(in_char) != jsle_pkg::SCRIPT_TAG[jsle_pkg::TAG_LEN-1])
        begin
            script_hit = 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.sel)
            jsle_pkg::SEL_HEAD:
            begin
                sel_byte   = head_reg;
                sel_script = head_script_reg;
            end
            jsle_pkg::SEL_LOOK:
            begin
                sel_byte   = look_reg[0];
                sel_script = 1'b0;
            end
            default:
            begin
                sel_byte   = jsle_pkg::CH_DQUOTE;
                sel_script = 1'b0;
            end
        endcase
    end

    assign emit_byte = cmd.pfx ? jsle_pkg::CH_BSLASH : jsle_pkg::esc_char(sel_byte);

    assign sts.count_zero = (count_reg == '0);
    assign sts.count_gt1  = (count_reg > jsle_pkg::la_count_t'(1));
    assign sts.count_full = full;
    assign sts.started    = started_reg;
    assign sts.quote_wrap = aq_reg;
    assign sts.need_pfx   = jsle_pkg::need_prefix(sel_byte, aq_reg, sel_script);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // lookahead bytes and head byte: payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load && cmd.ld_char)
        begin
            if (full)
            begin
                head_reg        <= look_reg[0];
                head_script_reg <= script_hit;
                for (int i = 0; i < jsle_pkg::LA_DEPTH - 1; i++)
                begin
                    look_reg[i] <= look_reg[i+1];
                end
                look_reg[jsle_pkg::LA_DEPTH-1] <= in_char;
            end
            else
            begin
                look_reg[count_reg] <= in_char;
            end
        end
        else if (cmd.consume)
        begin
            for (int i = 0; i < jsle_pkg::LA_DEPTH - 1; i++)
            begin
                look_reg[i] <= look_reg[i+1];
            end
        end
        if (cmd.emit)
        begin
            out_char_reg <= emit_byte;
            out_done_reg <= cmd.done;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            started_reg   <= 1'b0;
            aq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                aq_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                started_reg <= !cmd.ld_eos;
                if (cmd.ld_char && !full)
                begin
                    count_reg <= count_reg + 3'd1;
                end
            end
            else if (cmd.consume)
            begin
                count_reg <= count_reg - 3'd1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_done  = out_done_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // ------------------------------------------------------------------
    // Escape predictor + scoreboard
    // ------------------------------------------------------------------
    class escape_scoreboard;
        typedef struct {
            jsle_pkg::byte_t ch;
            logic            done;
            logic            last;
        } esc_byte_t;

        // predictor copy of the block state
        jsle_pkg::byte_t la_buf [jsle_pkg::LA_DEPTH];
        int unsigned     la_fill      = 0;
        bit              in_string    = 1'b0;
        bit              quotes_on    = 1'b0;

        esc_byte_t   expected_q [$];
        esc_byte_t   fresh_q [$];

        int unsigned errors         = 0;
        int unsigned reported       = 0;
        int unsigned items_seen     = 0;
        int unsigned bytes_checked  = 0;
        int unsigned strings_closed = 0;
        int unsigned tag_escapes    = 0;

        function void set_quotes(bit v);
            quotes_on = v;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // oldest buffered byte plus the next six (five buffered + new) spell /script
        function bit tag_match(jsle_pkg::byte_t nxt);
            jsle_pkg::byte_t b;
            for (int i = 0; i < jsle_pkg::TAG_LEN; i++)
            begin
                b = (i < jsle_pkg::LA_DEPTH) ? la_buf[i] : nxt;
                if (b >= jsle_pkg::CH_UP_A && b <= jsle_pkg::CH_UP_Z)
                begin
                    b = b + 8'd32;
                end
                if (b != jsle_pkg::SCRIPT_TAG[i])
                begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void emit(jsle_pkg::byte_t c);
            esc_byte_t e;
            e.ch   = c;
            e.done = 1'b0;
            e.last = 1'b0;
            if (fresh_q.size() < 16)
            begin
                fresh_q.push_back(e);
            end
        endfunction

        function void emit_escaped(jsle_pkg::byte_t c, bit tag_hit);
            case (c)
                jsle_pkg::CH_BSLASH:
                begin
                    emit(jsle_pkg::CH_BSLASH);
                    emit(jsle_pkg::CH_BSLASH);
                end
                jsle_pkg::CH_DQUOTE:
                begin
                    emit(jsle_pkg::CH_BSLASH);
                    emit(jsle_pkg::CH_DQUOTE);
                end
                jsle_pkg::CH_CR:
                begin
                    emit(jsle_pkg::CH_BSLASH);
                    emit(jsle_pkg::CH_LOW_R);
                end
                jsle_pkg::CH_LF:
                begin
                    emit(jsle_pkg::CH_BSLASH);
                    emit(jsle_pkg::CH_LOW_N);
                end
                jsle_pkg::CH_SQUOTE:
                begin
                    if (!quotes_on)
                    begin
                        emit(jsle_pkg::CH_BSLASH);
                    end
                    emit(jsle_pkg::CH_SQUOTE);
                end
                default:
                begin
                    if (c == jsle_pkg::CH_SLASH && tag_hit)
                    begin
                        emit(jsle_pkg::CH_BSLASH);
                        tag_escapes++;
                    end
                    emit(c);
                end
            endcase
        endfunction

        // one accepted input transaction
        function void note_item(jsle_pkg::byte_t c, bit nc, bit eos);
            bit hit;
            items_seen++;
            if (nc && !eos)
            begin
                return;
            end
            fresh_q.delete();
            if (!in_string)
            begin
                if (quotes_on)
                begin
                    emit(jsle_pkg::CH_DQUOTE);
                end
                in_string = 1'b1;
            end
            if (!nc)
            begin
                if (la_fill == jsle_pkg::LA_DEPTH)
                begin
                    hit = tag_match(c);
                    emit_escaped(la_buf[0], hit);
                    for (int i = 0; i < jsle_pkg::LA_DEPTH - 1; i++)
                    begin
                        la_buf[i] = la_buf[i + 1];
                    end
                    la_buf[jsle_pkg::LA_DEPTH - 1] = c;
                end
                else
                begin
                    la_buf[la_fill] = c;
                    la_fill++;
                end
            end
            if (eos)
            begin
                for (int i = 0; i < la_fill; i++)
                begin
                    emit_escaped(la_buf[i], 1'b0);
                end
                if (quotes_on)
                begin
                    emit(jsle_pkg::CH_DQUOTE);
                end
                if (fresh_q.size() > 0)
                begin
                    fresh_q[fresh_q.size() - 1].done = 1'b1;
                end
                la_fill   = 0;
                in_string = 1'b0;
                strings_closed++;
            end
            if (fresh_q.size() > 0)
            begin
                fresh_q[fresh_q.size() - 1].last = 1'b1;
            end
            foreach (fresh_q[i])
            begin
                expected_q.push_back(fresh_q[i]);
            end
        endfunction

        // one output transaction
        function void check_byte(jsle_pkg::byte_t c, logic d, logic l);
            esc_byte_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("%0t: ERROR unexpected output byte %02h done=%b last=%b",
                             $realtime, c, d, l);
                end
                return;
            end
            e = expected_q.pop_front();
            bytes_checked++;
            if (c !== e.ch || d !== e.done || l !== e.last)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("%0t: ERROR byte %0d exp char,done,last=%02h,%b,%b got %02h,%b,%b",
                             $realtime, bytes_checked, e.ch, e.done, e.last, c, d, l);
                end
            end
        endfunction

        function void drop_leftover();
            if (expected_q.size() > 0)
            begin
                errors += expected_q.size();
                if (reported < 10)
                begin
                    reported++;
                    $display("%0t: ERROR %0d expected output bytes never arrived",
                             $realtime, expected_q.size());
                end
                expected_q.delete();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic quotes_we;
    logic quotes_wdata;

    jsle_in_if  raw_if ();
    jsle_out_if esc_if ();

    escape_scoreboard sb = new();

    // sender burst bookkeeping: transactions left in the current burst
    int unsigned burst_left = 0;

    js_string_literal_escaper_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .raw_ch           (raw_if.sink),
        .esc_ch           (esc_if.source),
        .quote_wrap_we    (quotes_we),
        .quote_wrap_wdata (quotes_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop. Worst case is far below this: ~500 input transactions,
    // each at most 15 output bytes, each possibly held off by a receiver stall.
    initial
    begin
        #10_000_000;
        $display("js_string_literal_escaper_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: checks every output transaction, then drives ready from a
    // 32-bit stall mask that is redrawn once all its bits are used. Masks range from
    // always ready, through random, to mostly stalled.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_mask;
        int unsigned pos;
        esc_if.ready <= 1'b0;
        stall_mask = '1;
        pos = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && esc_if.valid && esc_if.ready)
            begin
                sb.check_byte(esc_if.out_char, esc_if.string_done, esc_if.run_last);
            end
            if (pos == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_mask = '1;
                    1:       stall_mask = $urandom;
                    2:       stall_mask = $urandom & $urandom;
                    default: stall_mask = $urandom | $urandom;
                endcase
            end
            esc_if.ready <= stall_mask[pos];
            pos = (pos + 1) % 32;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. Every task returns right after a rising edge, so the
    // next nonblocking drive always lands in a fresh time step.
    // ------------------------------------------------------------------

    // One input transaction. Bursts of 1..24 transactions, with idle gaps of
    // random length (often none) between them. Valid is lowered only for a gap,
    // so back-to-back transactions keep it high without a glitch.
    task automatic send_item(jsle_pkg::byte_t c, bit nc, bit eos);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                raw_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        raw_if.valid         <= 1'b1;
        raw_if.in_char       <= c;
        raw_if.no_char       <= nc;
        raw_if.end_of_string <= eos;
        do
            @(posedge clk);
        while (!raw_if.ready);
        sb.note_item(c, nc, eos);
    endtask

    task automatic send_text(string s, bit eos_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(s[i], 1'b0, eos_last && (i == s.len() - 1));
        end
    endtask

    // Stop sending, wait for every expected byte, then give the block time
    // to finish any transaction that yields nothing (ignored item, unquoted
    // empty string) before the register may be touched.
    task automatic settle();
        int unsigned waited;
        raw_if.valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        sb.drop_leftover();
        repeat (24) @(posedge clk);
    endtask

    task automatic write_quotes(bit v);
        quotes_we    <= 1'b1;
        quotes_wdata <= v;
        @(posedge clk);
        sb.set_quotes(v);
        quotes_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random content: strings are built from segments so that /script
    // (random case, sometimes damaged), escape characters and plain bytes
    // all show up often, including straddling the lookahead boundary.
    // ------------------------------------------------------------------
    jsle_pkg::byte_t seg_q [$];

    function automatic void fill_segment();
        int unsigned     r;
        int unsigned     idx;
        jsle_pkg::byte_t b;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            for (int i = 0; i < jsle_pkg::TAG_LEN; i++)
            begin
                b = jsle_pkg::SCRIPT_TAG[i];
                if (i > 0 && $urandom_range(0, 1) == 1)
                begin
                    b = b & ~jsle_pkg::CASE_BIT;
                end
                seg_q.push_back(b);
            end
            // near miss: one character damaged
            if ($urandom_range(0, 3) == 0)
            begin
                idx = seg_q.size() - 1 - $urandom_range(0, jsle_pkg::TAG_LEN - 1);
                seg_q[idx] = jsle_pkg::byte_t'($urandom_range(0, 255));
            end
            // doubled slash in front
            if ($urandom_range(0, 9) == 0)
            begin
                seg_q.push_front(jsle_pkg::CH_SLASH);
            end
        end
        else if (r < 60)
        begin
            case ($urandom_range(0, 7))
                0:       b = jsle_pkg::CH_BSLASH;
                1:       b = jsle_pkg::CH_DQUOTE;
                2:       b = jsle_pkg::CH_SQUOTE;
                3:       b = jsle_pkg::CH_CR;
                4:       b = jsle_pkg::CH_LF;
                5:       b = jsle_pkg::CH_SLASH;
                6:       b = 8'h00;
                default: b = 8'hFF;
            endcase
            seg_q.push_back(b);
        end
        else
        begin
            seg_q.push_back(jsle_pkg::byte_t'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        jsle_pkg::byte_t c;
        int unsigned     str_left;
        int unsigned     sent;

        rst_n                <= 1'b0;
        quotes_we            <= 1'b0;
        quotes_wdata         <= 1'b0;
        raw_if.valid         <= 1'b0;
        raw_if.in_char       <= 8'h00;
        raw_if.no_char       <= 1'b0;
        raw_if.end_of_string <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, unquoted ---
        write_quotes(1'b0);
        // byte extremes, every escape, an ignored empty transaction mid-string,
        // and enough bytes to fill the lookahead and push through it
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(jsle_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_item(jsle_pkg::CH_DQUOTE, 1'b0, 1'b0);
        send_item(jsle_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b0);
        send_item(jsle_pkg::CH_CR, 1'b0, 1'b0);
        send_item(jsle_pkg::CH_LF, 1'b0, 1'b0);
        send_item(jsle_pkg::CH_SQUOTE, 1'b0, 1'b0);
        send_item(jsle_pkg::CH_SLASH, 1'b0, 1'b1);
        // mixed-case tag gets its slash escaped
        send_text("/ScRiPt", 1'b0);
        send_item(8'h78, 1'b0, 1'b1);
        // empty string without quotes: nothing comes out
        send_item(8'h00, 1'b1, 1'b1);
        settle();

        // --- directed, quoted ---
        write_quotes(1'b1);
        // empty string with quotes: just the pair of quotes
        send_item(8'hFF, 1'b1, 1'b1);
        // single quote left alone, string closed by a byteless item
        send_item(jsle_pkg::CH_SQUOTE, 1'b0, 1'b0);
        send_item(8'h41, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // quoting switched off halfway through a string: opening quote
        // but no closing one, and the late single quote gets escaped
        send_text("ab", 1'b0);
        settle();
        write_quotes(1'b0);
        send_item(jsle_pkg::CH_SQUOTE, 1'b0, 1'b1);
        settle();

        // --- random phases; a phase may end mid-string, so the register
        // also changes while the lookahead holds bytes ---
        str_left = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_quotes(ph[0] ? 1'b0 : 1'b1);
            sent = 0;
            while (sent < 70)
            begin
                if (str_left == 0)
                begin
                    if ($urandom_range(0, 11) == 0)
                    begin
                        send_item(jsle_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b1);
                        sent++;
                        continue;
                    end
                    str_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                           : $urandom_range(1, 14);
                end
                // occasional ignored empty transaction inside the string
                if ($urandom_range(0, 15) == 0)
                begin
                    send_item(jsle_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b0);
                end
                if (seg_q.size() == 0)
                begin
                    fill_segment();
                end
                c = seg_q.pop_front();
                if (str_left == 1 && $urandom_range(0, 4) == 0)
                begin
                    send_item(c, 1'b0, 1'b0);
                    send_item(jsle_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b1);
                    sent += 2;
                end
                else
                begin
                    send_item(c, 1'b0, str_left == 1);
                    sent++;
                end
                str_left--;
            end
            settle();
        end
        if (str_left != 0)
        begin
            send_item(jsle_pkg::byte_t'($urandom_range(0, 255)), 1'b1, 1'b1);
            settle();
        end

        $display("Run covered %0d input transactions, %0d escaped output bytes, %0d strings.",
                 sb.items_seen, sb.bytes_checked, sb.strings_closed);
        $display("Slashes escaped ahead of a script tag: %0d; mismatches: %0d.",
                 sb.tag_escapes, sb.errors);
        if (sb.errors == 0)
        begin
            $display("js_string_literal_escaper_unit test passed");
        end
        else
        begin
            $display("js_string_literal_escaper_unit test failed");
        end
        $finish;
    end

endmodule
